// ===== sv/deque_with_key_search_macros.svh =====
// Assertion macros shared by the deque with key search RTL.
`ifndef DEQUE_WITH_KEY_SEARCH_MACROS_SVH
`define DEQUE_WITH_KEY_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DQKS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DQKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dqks_pkg.sv =====
// Types and constants shared by the deque with key search modules.
`default_nettype none

package dqks_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int DATA_W      = 32;
    localparam int OPCODE_W    = 3;
    localparam int STATUS_W    = 2;
    localparam int POSITION_W  = 4;
    localparam int OCCUPANCY_W = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_SEARCH = 1'b1
    } t_state;

    typedef struct packed {
        logic shift_right;
        logic shift_left;
        logic compare;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== sv/dqks_cell.sv =====
// One storage cell of the deque chain with its key comparator and first-match link.
`default_nettype none

module dqks_cell (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire dqks_pkg::t_cell_ctrl                i_ctrl,
    input  wire logic                                i_load,
    input  wire logic                                i_held,
    input  wire logic signed [dqks_pkg::DATA_W-1:0]  i_value,
    input  wire logic signed [dqks_pkg::DATA_W-1:0]  i_prev_data,
    input  wire logic signed [dqks_pkg::DATA_W-1:0]  i_next_data,
    input  wire logic                                i_seen,
    output logic signed [dqks_pkg::DATA_W-1:0]       o_data,
    output logic                                     o_seen,
    output logic                                     o_first
);

    logic signed [dqks_pkg::DATA_W-1:0] r_data;
    logic                               r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_right) begin
            r_data <= i_prev_data;
        end else if (i_ctrl.shift_left) begin
            r_data <= i_next_data;
        end else if (i_load) begin
            r_data <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctrl.compare) begin
            r_match <= i_held && (r_data == i_value);
        end
    end

    assign o_data  = r_data;
    assign o_first = r_match && !i_seen;
    assign o_seen  = r_match || i_seen;

endmodule

`default_nettype wire

// ===== sv/deque_with_key_search.sv =====
// Top level of the bounded deque of signed 32-bit values with key search.
`default_nettype none

// The deque is a chain of DEPTH cells with the front entry always in cell 0: a push at the
// front shifts every cell one place back, a pop at the front shifts every cell one place
// forward, and a push or pop at the back only writes the cell at the fill count or moves the
// count. A search beat first has every cell register the compare of its entry with the key,
// then in the search state lets the match ripple down the chain and be encoded into a
// position. Each beat's result sits in an output register; a new beat is taken when no
// search is pending and that register is free or being drained in the same cycle.
module deque_with_key_search #(
    parameter int DEPTH = dqks_pkg::DEPTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [dqks_pkg::OPCODE_W-1:0]         i_opcode,
    input  wire logic signed [dqks_pkg::DATA_W-1:0]    i_operand_value,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [dqks_pkg::STATUS_W-1:0]              o_status,
    output logic                                       o_found,
    output logic [dqks_pkg::POSITION_W-1:0]            o_position,
    output logic [dqks_pkg::OCCUPANCY_W-1:0]           o_occupancy
);

    `include "deque_with_key_search_macros.svh"

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dqks_pkg::t_state                        r_state;
    dqks_pkg::t_state                        n_state;
    logic [CNT_W-1:0]                        r_count;
    logic [CNT_W-1:0]                        n_count;
    logic                                    r_out_valid;
    dqks_pkg::t_status                       r_status;
    logic                                    r_found;
    logic [dqks_pkg::POSITION_W-1:0]         r_position;
    logic [dqks_pkg::OCCUPANCY_W-1:0]        r_occupancy;

    logic                                    w_fire;
    logic                                    w_full;
    logic                                    w_empty;
    logic                                    w_load_op;
    logic                                    w_load_search;
    logic                                    w_load_back;
    dqks_pkg::t_status                       w_status;
    dqks_pkg::t_cell_ctrl                    w_ctrl;
    logic [IDX_W-1:0]                        w_pos;
    logic [IDX_W+dqks_pkg::POSITION_W-1:0]   w_pos_ext;
    logic [CNT_W+dqks_pkg::OCCUPANCY_W-1:0]  w_cnt_ext;
    logic [CNT_W+dqks_pkg::OCCUPANCY_W-1:0]  w_occ_ext;

    logic signed [dqks_pkg::DATA_W-1:0]      w_data [DEPTH];
    logic signed [dqks_pkg::DATA_W-1:0]      w_prev [DEPTH];
    logic signed [dqks_pkg::DATA_W-1:0]      w_next [DEPTH];
    logic [DEPTH:0]                          w_seen;
    logic [DEPTH-1:0]                        w_first;
    logic [DEPTH-1:0]                        w_load;
    logic [DEPTH-1:0]                        w_held;

    assign o_in_ready = (r_state == dqks_pkg::S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);

    always_comb begin
        n_count            = r_count;
        w_status           = dqks_pkg::ST_DONE;
        w_ctrl.shift_right = 1'b0;
        w_ctrl.shift_left  = 1'b0;
        w_ctrl.compare     = 1'b0;
        w_load_back        = 1'b0;
        unique case (dqks_pkg::t_op'(i_opcode))
            dqks_pkg::OP_PUSH_BACK: begin
                if (w_full) begin
                    w_status = dqks_pkg::ST_FULL;
                end else begin
                    w_load_back = w_fire;
                    n_count     = r_count + CNT_W'(1);
                end
            end
            dqks_pkg::OP_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = dqks_pkg::ST_FULL;
                end else begin
                    w_ctrl.shift_right = w_fire;
                    n_count            = r_count + CNT_W'(1);
                end
            end
            dqks_pkg::OP_POP_FRONT: begin
                if (w_empty) begin
                    w_status = dqks_pkg::ST_EMPTY;
                end else begin
                    w_ctrl.shift_left = w_fire;
                    n_count           = r_count - CNT_W'(1);
                end
            end
            dqks_pkg::OP_POP_BACK: begin
                if (w_empty) begin
                    w_status = dqks_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            dqks_pkg::OP_SEARCH: begin
                w_ctrl.compare = w_fire;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state       = r_state;
        w_load_op     = 1'b0;
        w_load_search = 1'b0;
        unique case (r_state)
            dqks_pkg::S_IDLE: begin
                if (w_fire) begin
                    if (dqks_pkg::t_op'(i_opcode) == dqks_pkg::OP_SEARCH) begin
                        n_state = dqks_pkg::S_SEARCH;
                    end else begin
                        w_load_op = 1'b1;
                    end
                end
            end
            dqks_pkg::S_SEARCH: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_search = 1'b1;
                    n_state       = dqks_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dqks_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dqks_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_fire) begin
            r_count <= n_count;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_prev[g] = i_operand_value;
            end else begin : g_body
                assign w_prev[g] = w_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign w_next[g] = w_data[g];
            end else begin : g_link
                assign w_next[g] = w_data[g+1];
            end
            assign w_load[g] = w_load_back && (r_count == CNT_W'(g));
            assign w_held[g] = (CNT_W'(g) < r_count);

            dqks_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_ctrl),
                .i_load      (w_load[g]),
                .i_held      (w_held[g]),
                .i_value     (i_operand_value),
                .i_prev_data (w_prev[g]),
                .i_next_data (w_next[g]),
                .i_seen      (w_seen[g]),
                .o_data      (w_data[g]),
                .o_seen      (w_seen[g+1]),
                .o_first     (w_first[g])
            );
        end
    endgenerate

    assign w_seen[0] = 1'b0;

    always_comb begin
        w_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_first[i]) begin
                w_pos = w_pos | IDX_W'(i);
            end
        end
    end

    assign w_pos_ext = {{dqks_pkg::POSITION_W{1'b0}}, w_pos};
    assign w_cnt_ext = {{dqks_pkg::OCCUPANCY_W{1'b0}}, n_count};
    assign w_occ_ext = {{dqks_pkg::OCCUPANCY_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_op || w_load_search) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_op) begin
            r_status    <= w_status;
            r_found     <= 1'b0;
            r_position  <= '0;
            r_occupancy <= w_cnt_ext[dqks_pkg::OCCUPANCY_W-1:0];
        end else if (w_load_search) begin
            r_status    <= dqks_pkg::ST_DONE;
            r_found     <= w_seen[DEPTH];
            r_position  <= w_pos_ext[dqks_pkg::POSITION_W-1:0];
            r_occupancy <= w_occ_ext[dqks_pkg::OCCUPANCY_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_found     = r_found;
    assign o_position  = r_position;
    assign o_occupancy = r_occupancy;

    `DQKS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH),
        "Entry count exceeds the deque depth.")
    `DQKS_ASSERT_NOW(a_first_unique, i_clk, i_rst_n, 1'b1, $onehot0(w_first),
        "More than one cell claims the first match.")
    `DQKS_ASSERT_NEXT(a_search_holds, i_clk, i_rst_n,
        w_fire && (dqks_pkg::t_op'(i_opcode) == dqks_pkg::OP_SEARCH),
        (r_state == dqks_pkg::S_SEARCH) && $stable(r_count),
        "A search beat must enter the search state without changing the count.")
    `DQKS_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n,
        w_fire && !w_full && ((dqks_pkg::t_op'(i_opcode) == dqks_pkg::OP_PUSH_BACK)
        || (dqks_pkg::t_op'(i_opcode) == dqks_pkg::OP_PUSH_FRONT)),
        r_count == $past(r_count) + CNT_W'(1),
        "An accepted push must grow the count by one.")

endmodule

`default_nettype wire
